### rtl/rim_pkg.sv
// shared types, codes and sizes of the rendezvous ipc matcher
package rim_pkg;

	localparam int NUM_PROCS = 16;
	localparam int PID_W = 4;
	localparam int CODE_W = 5;
	localparam int CNT_W = $clog2(NUM_PROCS + 1);
	localparam int ADDR_W = 32;

	localparam logic [CODE_W-1:0] NUM_CODE = CODE_W'(NUM_PROCS);
	localparam logic [CODE_W-1:0] PEER_ANY = 5'd16;
	localparam logic [CODE_W-1:0] PEER_INT = 5'd17;
	localparam logic [CODE_W-1:0] NO_SOURCE = 5'd18;
	localparam logic [CODE_W-1:0] Q_EMPTY = 5'd16;

	localparam logic [1:0] MODE_SEND = 2'd0;
	localparam logic [1:0] MODE_RECV = 2'd1;
	localparam logic [1:0] MODE_INT = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_SEND = 2'd1;
	localparam logic [1:0] ST_RECV = 2'd2;

	localparam logic [2:0] RS_DELIVERED = 3'd0;
	localparam logic [2:0] RS_BLOCKED = 3'd1;
	localparam logic [2:0] RS_DEADLOCK = 3'd2;
	localparam logic [2:0] RS_INT_WRITTEN = 3'd3;
	localparam logic [2:0] RS_INT_PENDING = 3'd4;
	localparam logic [2:0] RS_REJECTED = 3'd5;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_REJECT,
		OP_INT_WRITE,
		OP_INT_PEND,
		OP_INT_TAKE,
		OP_CYC_START,
		OP_CYC_STEP,
		OP_DEADLOCK,
		OP_SEND_DELIVER,
		OP_SEND_BLOCK,
		OP_ENQ_STEP,
		OP_ENQ_LINK,
		OP_RECV_BLOCK,
		OP_FROM_HEAD,
		OP_FROM_PEER,
		OP_DQ_INIT,
		OP_DQ_STEP,
		OP_DQ_UNLINK,
		OP_FIN_DELIVER
	} op_t;

	typedef enum logic [1:0] {
		RD_CALLER,
		RD_PEER,
		RD_PTR,
		RD_FROM
	} rd_sel_t;

	typedef struct packed {
		op_t op;
		rd_sel_t rd;
	} ctl_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic bad_call;
		logic is_int;
		logic is_send;
		logic int_ready;
		logic reject;
		logic int_take;
		logic peer_any;
		logic peer_int;
		logic qh_ok;
		logic nx_ok;
		logic p_ok;
		logic n_full;
		logic walk_end;
		logic hit;
		logic recv_match;
		logic src_match;
		logic p_is_from;
	} dp_flags_t;

endpackage

### rtl/rim_if.sv
// request and response channel interfaces of the ipc matcher
interface rim_req_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [3:0] caller;
	logic [4:0] peer;
	logic [31:0] buffer_addr;

	modport source(output valid, mode, caller, peer, buffer_addr, input ready);
	modport sink(input valid, mode, caller, peer, buffer_addr, output ready);
endinterface

interface rim_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [3:0] from_pid;
	logic [31:0] from_addr;
	logic [3:0] to_pid;
	logic [31:0] to_addr;
	logic woken_valid;
	logic [3:0] woken_pid;

	modport source(output valid, status, from_pid, from_addr, to_pid, to_addr,
		woken_valid, woken_pid, input ready);
	modport sink(input valid, status, from_pid, from_addr, to_pid, to_addr,
		woken_valid, woken_pid, output ready);
endinterface

### rtl/rim_ctrl.sv
// sequencing state machine of the ipc matcher
module rim_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rim_pkg::dp_flags_t flags,
	output rim_pkg::ctl_cmd_t  cmd
);
	import rim_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_WAITO, S_CHECK, S_CYC, S_MATCH, S_ENQ, S_RSRC, S_DQH, S_DQW, S_FIN
	} state_t;

	state_t state_q, state_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd.op = OP_NONE;
		cmd.rd = RD_CALLER;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_nxt = S_WAITO;
				end
			end
			S_WAITO: begin
				if (flags.slot_free) state_nxt = S_CHECK;
			end
			S_CHECK: begin
				cmd.rd = RD_CALLER;
				state_nxt = S_IDLE;
				if (flags.bad_call) cmd.op = OP_REJECT;
				else if (flags.is_int) cmd.op = flags.int_ready ? OP_INT_WRITE : OP_INT_PEND;
				else if (flags.reject) cmd.op = OP_REJECT;
				else if (flags.is_send) begin
					cmd.op = OP_CYC_START;
					state_nxt = S_CYC;
				end else if (flags.int_take) cmd.op = OP_INT_TAKE;
				else if (flags.peer_any) begin
					if (flags.qh_ok) begin
						cmd.op = OP_FROM_HEAD;
						state_nxt = S_DQH;
					end else cmd.op = OP_RECV_BLOCK;
				end else if (flags.peer_int) cmd.op = OP_RECV_BLOCK;
				else state_nxt = S_RSRC;
			end
			S_CYC: begin
				cmd.rd = RD_PTR;
				if (flags.walk_end) state_nxt = S_MATCH;
				else if (flags.hit) begin
					cmd.op = OP_DEADLOCK;
					state_nxt = S_IDLE;
				end else cmd.op = OP_CYC_STEP;
			end
			S_MATCH: begin
				cmd.rd = RD_PEER;
				if (flags.recv_match) begin
					cmd.op = OP_SEND_DELIVER;
					state_nxt = S_IDLE;
				end else begin
					cmd.op = OP_SEND_BLOCK;
					state_nxt = flags.qh_ok ? S_ENQ : S_IDLE;
				end
			end
			S_ENQ: begin
				cmd.rd = RD_PTR;
				if (flags.n_full || !flags.nx_ok) begin
					cmd.op = OP_ENQ_LINK;
					state_nxt = S_IDLE;
				end else cmd.op = OP_ENQ_STEP;
			end
			S_RSRC: begin
				cmd.rd = RD_PEER;
				if (flags.src_match) begin
					cmd.op = OP_FROM_PEER;
					state_nxt = S_DQH;
				end else begin
					cmd.op = OP_RECV_BLOCK;
					state_nxt = S_IDLE;
				end
			end
			S_DQH: begin
				cmd.rd = RD_CALLER;
				cmd.op = OP_DQ_INIT;
				state_nxt = S_DQW;
			end
			S_DQW: begin
				cmd.rd = RD_PTR;
				if (flags.n_full || !flags.p_ok) state_nxt = S_FIN;
				else if (flags.p_is_from) begin
					cmd.op = OP_DQ_UNLINK;
					state_nxt = S_FIN;
				end else cmd.op = OP_DQ_STEP;
			end
			S_FIN: begin
				cmd.rd = RD_FROM;
				cmd.op = OP_FIN_DELIVER;
				state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end
endmodule

### rtl/rim_dp.sv
// process tables, walk registers and result register of the ipc matcher
module rim_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rim_pkg::ctl_cmd_t             cmd,
	input  logic [1:0]                    mode,
	input  logic [rim_pkg::PID_W-1:0]     caller,
	input  logic [rim_pkg::CODE_W-1:0]    peer,
	input  logic [rim_pkg::ADDR_W-1:0]    buffer_addr,
	output rim_pkg::dp_flags_t            flags,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [2:0]                    status,
	output logic [rim_pkg::PID_W-1:0]     from_pid,
	output logic [rim_pkg::ADDR_W-1:0]    from_addr,
	output logic [rim_pkg::PID_W-1:0]     to_pid,
	output logic [rim_pkg::ADDR_W-1:0]    to_addr,
	output logic                          woken_valid,
	output logic [rim_pkg::PID_W-1:0]     woken_pid
);
	import rim_pkg::*;

	logic [1:0]        bs_q [NUM_PROCS];
	logic [PID_W-1:0]  st_q [NUM_PROCS];
	logic [CODE_W-1:0] rs_q [NUM_PROCS];
	logic [ADDR_W-1:0] sb_q [NUM_PROCS];
	logic              ip_q [NUM_PROCS];
	logic [CODE_W-1:0] qh_q [NUM_PROCS];
	logic [CODE_W-1:0] qn_q [NUM_PROCS];

	logic [1:0]        mode_q;
	logic [PID_W-1:0]  c_q, from_q;
	logic [CODE_W-1:0] peer_q, p_q, prev_q;
	logic [ADDR_W-1:0] buf_q;
	logic [CNT_W-1:0]  n_q;

	logic [PID_W-1:0]  rd_idx;
	logic [1:0]        bs_r;
	logic [PID_W-1:0]  st_r;
	logic [CODE_W-1:0] rs_r, qh_r, qn_r;
	logic [ADDR_W-1:0] sb_r;
	logic              ip_r;
	logic [CODE_W-1:0] c_ext;
	logic              peer_pid;

	logic              emit;
	logic [2:0]        n_status;
	logic [PID_W-1:0]  n_from_pid, n_to_pid, n_woken_pid;
	logic [ADDR_W-1:0] n_from_addr, n_to_addr;
	logic              n_woken_valid;

	always_comb begin
		case (cmd.rd)
			RD_CALLER: rd_idx = c_q;
			RD_PEER:   rd_idx = peer_q[PID_W-1:0];
			RD_PTR:    rd_idx = p_q[PID_W-1:0];
			default:   rd_idx = from_q;
		endcase
	end

	assign bs_r = bs_q[rd_idx];
	assign st_r = st_q[rd_idx];
	assign rs_r = rs_q[rd_idx];
	assign sb_r = sb_q[rd_idx];
	assign ip_r = ip_q[rd_idx];
	assign qh_r = qh_q[rd_idx];
	assign qn_r = qn_q[rd_idx];
	assign c_ext = {1'b0, c_q};
	assign peer_pid = peer_q < NUM_CODE;

	always_comb begin
		flags.slot_free  = !rsp_valid || rsp_ready;
		flags.bad_call   = (mode_q == MODE_BAD) || (c_ext >= NUM_CODE);
		flags.is_int     = (mode_q == MODE_INT);
		flags.is_send    = (mode_q == MODE_SEND);
		flags.peer_any   = (peer_q == PEER_ANY);
		flags.peer_int   = (peer_q == PEER_INT);
		flags.int_ready  = (bs_r == ST_RECV) && (rs_r == PEER_INT || rs_r == PEER_ANY);
		flags.reject     = (peer_q == c_ext) || (bs_r != ST_RUN) ||
			(!flags.peer_any && !flags.peer_int && !peer_pid) ||
			((mode_q == MODE_SEND) && !peer_pid);
		flags.int_take   = ip_r && (flags.peer_any || flags.peer_int);
		flags.qh_ok      = qh_r < NUM_CODE;
		flags.nx_ok      = qn_r < NUM_CODE;
		flags.p_ok       = p_q < NUM_CODE;
		flags.n_full     = (n_q == CNT_W'(NUM_PROCS));
		flags.walk_end   = flags.n_full || !flags.p_ok || (bs_r != ST_SEND);
		flags.hit        = (st_r == c_q);
		flags.recv_match = (bs_r == ST_RECV) && (rs_r == c_ext || rs_r == PEER_ANY);
		flags.src_match  = (bs_r == ST_SEND) && (st_r == c_q);
		flags.p_is_from  = (p_q == {1'b0, from_q});
	end

	always_comb begin
		emit = 1'b1;
		n_status = RS_REJECTED;
		n_from_pid = '0;
		n_from_addr = '0;
		n_to_pid = '0;
		n_to_addr = '0;
		n_woken_valid = 1'b0;
		n_woken_pid = '0;
		case (cmd.op)
			OP_REJECT: n_status = RS_REJECTED;
			OP_INT_PEND: n_status = RS_INT_PENDING;
			OP_DEADLOCK: n_status = RS_DEADLOCK;
			OP_SEND_BLOCK, OP_RECV_BLOCK: n_status = RS_BLOCKED;
			OP_INT_WRITE: begin
				n_status = RS_INT_WRITTEN;
				n_to_pid = c_q;
				n_to_addr = sb_r;
				n_woken_valid = 1'b1;
				n_woken_pid = c_q;
			end
			OP_INT_TAKE: begin
				n_status = RS_INT_WRITTEN;
				n_to_pid = c_q;
				n_to_addr = buf_q;
			end
			OP_SEND_DELIVER: begin
				n_status = RS_DELIVERED;
				n_from_pid = c_q;
				n_from_addr = buf_q;
				n_to_pid = rd_idx;
				n_to_addr = sb_r;
				n_woken_valid = 1'b1;
				n_woken_pid = rd_idx;
			end
			OP_FIN_DELIVER: begin
				n_status = RS_DELIVERED;
				n_from_pid = from_q;
				n_from_addr = sb_r;
				n_to_pid = c_q;
				n_to_addr = buf_q;
				n_woken_valid = 1'b1;
				n_woken_pid = from_q;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PROCS; i++) begin
				bs_q[i] <= ST_RUN;
				st_q[i] <= '0;
				rs_q[i] <= NO_SOURCE;
				sb_q[i] <= '0;
				ip_q[i] <= 1'b0;
				qh_q[i] <= Q_EMPTY;
				qn_q[i] <= Q_EMPTY;
			end
			rsp_valid <= 1'b0;
		end else begin
			rsp_valid <= emit || (rsp_valid && !rsp_ready);
			case (cmd.op)
				OP_INT_WRITE: begin
					bs_q[c_q] <= ST_RUN;
					st_q[c_q] <= '0;
					rs_q[c_q] <= NO_SOURCE;
					sb_q[c_q] <= '0;
					ip_q[c_q] <= 1'b0;
				end
				OP_INT_PEND: ip_q[c_q] <= 1'b1;
				OP_INT_TAKE: ip_q[c_q] <= 1'b0;
				OP_SEND_DELIVER, OP_FIN_DELIVER: begin
					bs_q[rd_idx] <= ST_RUN;
					st_q[rd_idx] <= '0;
					rs_q[rd_idx] <= NO_SOURCE;
					sb_q[rd_idx] <= '0;
				end
				OP_SEND_BLOCK: begin
					bs_q[c_q] <= ST_SEND;
					st_q[c_q] <= peer_q[PID_W-1:0];
					sb_q[c_q] <= buf_q;
					qn_q[c_q] <= Q_EMPTY;
					if (!flags.qh_ok) qh_q[rd_idx] <= c_ext;
				end
				OP_ENQ_LINK: qn_q[p_q[PID_W-1:0]] <= c_ext;
				OP_RECV_BLOCK: begin
					bs_q[c_q] <= ST_RECV;
					sb_q[c_q] <= buf_q;
					rs_q[c_q] <= peer_q;
				end
				OP_DQ_UNLINK: begin
					if (prev_q < NUM_CODE) qn_q[prev_q[PID_W-1:0]] <= qn_r;
					else qh_q[c_q] <= qn_r;
					qn_q[from_q] <= Q_EMPTY;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status <= n_status;
			from_pid <= n_from_pid;
			from_addr <= n_from_addr;
			to_pid <= n_to_pid;
			to_addr <= n_to_addr;
			woken_valid <= n_woken_valid;
			woken_pid <= n_woken_pid;
		end
		case (cmd.op)
			OP_LOAD: begin
				mode_q <= mode;
				c_q <= caller;
				peer_q <= peer;
				buf_q <= buffer_addr;
			end
			OP_CYC_START: begin
				p_q <= peer_q;
				n_q <= '0;
			end
			OP_CYC_STEP: begin
				p_q <= {1'b0, st_r};
				n_q <= n_q + 1'b1;
			end
			OP_SEND_BLOCK: begin
				p_q <= qh_r;
				n_q <= '0;
			end
			OP_ENQ_STEP: begin
				p_q <= qn_r;
				n_q <= n_q + 1'b1;
			end
			OP_FROM_HEAD: from_q <= qh_r[PID_W-1:0];
			OP_FROM_PEER: from_q <= peer_q[PID_W-1:0];
			OP_DQ_INIT: begin
				p_q <= qh_r;
				prev_q <= Q_EMPTY;
				n_q <= '0;
			end
			OP_DQ_STEP: begin
				prev_q <= p_q;
				p_q <= qn_r;
				n_q <= n_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule

### rtl/rendezvous_ipc_matcher.sv
// top level of the rendezvous ipc matcher
// One call is taken at a time. A call settled at the first check (reject, interrupt notice,
// receive from any or the interrupt source that blocks or takes a pending interrupt) gives
// its result straight from that check; a send first walks the send chain of blocked processes
// (up to 16), and a send that blocks then walks the destination's queue before the next call
// is taken; a receive that takes a queued sender walks its queue up to that sender, and one
// that names the sender checks that sender first. The chain and queue walks through the
// per-process tables, one entry a cycle, set the rate. A finished result waits in the output
// register while the next call is accepted.
module rendezvous_ipc_matcher (
	input logic     clk,
	input logic     arst_n,
	rim_req_if.sink req,
	rim_rsp_if.source rsp
);
	import rim_pkg::*;

	ctl_cmd_t  cmd;
	dp_flags_t flags;

	rim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.flags    (flags),
		.cmd      (cmd)
	);

	rim_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (req.mode),
		.caller      (req.caller),
		.peer        (req.peer),
		.buffer_addr (req.buffer_addr),
		.flags       (flags),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.status      (rsp.status),
		.from_pid    (rsp.from_pid),
		.from_addr   (rsp.from_addr),
		.to_pid      (rsp.to_pid),
		.to_addr     (rsp.to_addr),
		.woken_valid (rsp.woken_valid),
		.woken_pid   (rsp.woken_pid)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second item accepted while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status <= RS_REJECTED)
		else $error("result status out of range");

	a_woken_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.woken_valid |->
		rsp.status == RS_DELIVERED || rsp.status == RS_INT_WRITTEN)
		else $error("process woken by a result that delivers nothing");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD |-> req.ready && req.valid)
		else $error("item latched without a handshake");
endmodule

### dv/rim_tb_if.sv
// shared constants of the ipc matcher testbench
`timescale 1ns / 100ps
package rim_tb_pkg;
	localparam int CHECK_LIMIT = 10;
endpackage

### dv/testbench.sv
// testbench of the rendezvous ipc matcher: random and directed calls checked against a predictor
`timescale 1ns / 100ps
module testbench;
	import rim_pkg::*;
	import rim_tb_pkg::*;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] from_pid;
		logic [31:0] from_addr;
		logic [3:0] to_pid;
		logic [31:0] to_addr;
		logic woken_valid;
		logic [3:0] woken_pid;
	} ipc_result_t;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	rim_req_if req();
	rim_rsp_if rsp();

	rendezvous_ipc_matcher dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// predictor state
	logic [1:0] pst [16];
	logic [3:0] ptarget [16];
	logic [4:0] psource [16];
	logic [31:0] pbuf [16];
	logic pint [16];
	logic [4:0] qhead [16];
	logic [4:0] qnext [16];

	ipc_result_t expected_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int status_count [8];
	longint cycles = 0;
	int hold_off = 0;
	bit hold_active = 0;
	bit drain_done = 0;

	function automatic void clear_proc(int p);
		pst[p] = ST_RUN;
		ptarget[p] = '0;
		psource[p] = NO_SOURCE;
		pbuf[p] = '0;
	endfunction

	function automatic void reset_model();
		for (int i = 0; i < 16; i++) begin
			clear_proc(i);
			pint[i] = 1'b0;
			qhead[i] = Q_EMPTY;
			qnext[i] = Q_EMPTY;
		end
	endfunction

	function automatic ipc_result_t mk(logic [2:0] st, int fp, logic [31:0] fa, int tp,
			logic [31:0] ta, int wv, int wp);
		ipc_result_t r;
		r.status = st;
		r.from_pid = 4'(fp);
		r.from_addr = fa;
		r.to_pid = 4'(tp);
		r.to_addr = ta;
		r.woken_valid = 1'(wv);
		r.woken_pid = 4'(wp);
		return r;
	endfunction

	function automatic bit closes_cycle(int src, int dest);
		int p;
		p = dest;
		for (int n = 0; n < 16; n++) begin
			if (p > 15 || pst[p] != ST_SEND)
				return 0;
			if (ptarget[p] == src)
				return 1;
			p = ptarget[p];
		end
		return 0;
	endfunction

	function automatic void queue_append(int dest, int s);
		int p;
		p = qhead[dest];
		qnext[s] = Q_EMPTY;
		if (p > 15) begin
			qhead[dest] = 5'(s);
			return;
		end
		for (int n = 0; n < 16; n++) begin
			if (qnext[p] > 15)
				break;
			p = qnext[p];
		end
		qnext[p] = 5'(s);
	endfunction

	function automatic void queue_remove(int dest, int s);
		int p;
		int prev;
		p = qhead[dest];
		prev = Q_EMPTY;
		for (int n = 0; n < 16 && p < 16; n++) begin
			if (p == s) begin
				if (prev < 16)
					qnext[prev] = qnext[s];
				else
					qhead[dest] = qnext[s];
				qnext[s] = Q_EMPTY;
				return;
			end
			prev = p;
			p = qnext[p];
		end
	endfunction

	function automatic ipc_result_t predict_call(logic [1:0] mode, logic [3:0] c_in,
			logic [4:0] peer, logic [31:0] addr);
		int c;
		int d;
		int from;
		logic [31:0] ta;
		logic [31:0] fa;
		c = c_in;
		if (mode == MODE_BAD)
			return mk(RS_REJECTED, 0, 0, 0, 0, 0, 0);
		if (mode == MODE_INT) begin
			if (pst[c] == ST_RECV && (psource[c] == PEER_INT || psource[c] == PEER_ANY)) begin
				ta = pbuf[c];
				clear_proc(c);
				pint[c] = 1'b0;
				return mk(RS_INT_WRITTEN, 0, 0, c, ta, 1, c);
			end
			pint[c] = 1'b1;
			return mk(RS_INT_PENDING, 0, 0, 0, 0, 0, 0);
		end
		if (peer == c || pst[c] != ST_RUN || peer > PEER_INT)
			return mk(RS_REJECTED, 0, 0, 0, 0, 0, 0);
		if (mode == MODE_SEND) begin
			if (peer > 15)
				return mk(RS_REJECTED, 0, 0, 0, 0, 0, 0);
			d = peer;
			if (closes_cycle(c, d))
				return mk(RS_DEADLOCK, 0, 0, 0, 0, 0, 0);
			if (pst[d] == ST_RECV && (psource[d] == c || psource[d] == PEER_ANY)) begin
				ta = pbuf[d];
				clear_proc(d);
				return mk(RS_DELIVERED, c, addr, d, ta, 1, d);
			end
			pst[c] = ST_SEND;
			ptarget[c] = 4'(d);
			pbuf[c] = addr;
			queue_append(d, c);
			return mk(RS_BLOCKED, 0, 0, 0, 0, 0, 0);
		end
		if (pint[c] && (peer == PEER_ANY || peer == PEER_INT)) begin
			pint[c] = 1'b0;
			return mk(RS_INT_WRITTEN, 0, 0, c, addr, 0, 0);
		end
		from = Q_EMPTY;
		if (peer == PEER_ANY) begin
			if (qhead[c] < 16)
				from = qhead[c];
		end else if (peer != PEER_INT) begin
			if (pst[peer] == ST_SEND && ptarget[peer] == c)
				from = peer;
		end
		if (from < 16) begin
			fa = pbuf[from];
			queue_remove(c, from);
			clear_proc(from);
			return mk(RS_DELIVERED, from, fa, c, addr, 1, from);
		end
		pst[c] = ST_RECV;
		pbuf[c] = addr;
		psource[c] = peer;
		return mk(RS_BLOCKED, 0, 0, 0, 0, 0, 0);
	endfunction

	function automatic int short_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
	endfunction

	task automatic send_call(logic [1:0] mode, logic [3:0] c, logic [4:0] peer,
			logic [31:0] addr);
		int gap;
		gap = short_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= mode;
		req.caller <= c;
		req.peer <= peer;
		req.buffer_addr <= addr;
		do @(posedge clk); while (!req.ready);
		expected_results.push_back(predict_call(mode, c, peer, addr));
		items_sent++;
	endtask

	initial begin
		req.valid = 1'b0;
		req.mode = '0;
		req.caller = '0;
		req.peer = '0;
		req.buffer_addr = '0;
		rsp.ready = 1'b0;
	end

	// receiver side with random stalls, a few longer ones and one long hold-off
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 1'b0;
		end else if (hold_active) begin
			hold_active <= 1'b0;
			hold_off <= 400;
			rsp.ready <= 1'b0;
		end else if ($urandom_range(0, 199) == 0) begin
			hold_off <= $urandom_range(10, 40);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 1) == 0);
		end
	end

	always @(posedge clk) begin
		ipc_result_t got;
		ipc_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.status = rsp.status;
			got.from_pid = rsp.from_pid;
			got.from_addr = rsp.from_addr;
			got.to_pid = rsp.to_pid;
			got.to_addr = rsp.to_addr;
			got.woken_valid = rsp.woken_valid;
			got.woken_pid = rsp.woken_pid;
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= CHECK_LIMIT)
					$display("unexpected result %p", got);
			end else begin
				exp_r = expected_results.pop_front();
				status_count[exp_r.status]++;
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= CHECK_LIMIT)
						$display("mismatch: expected %p actual %p", exp_r, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 2000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic test_rejects();
		send_call(MODE_BAD, 4'd15, 5'd0, 32'hFFFF_FFFF);
		send_call(MODE_SEND, 4'd3, 5'd3, 32'h1);
		send_call(MODE_SEND, 4'd3, PEER_ANY, 32'h2);
		send_call(MODE_SEND, 4'd3, PEER_INT, 32'h3);
		send_call(MODE_RECV, 4'd0, 5'd31, 32'h4);
		send_call(MODE_SEND, 4'd0, 5'd18, 32'h5);
	endtask

	task automatic test_rendezvous();
		send_call(MODE_RECV, 4'd1, PEER_ANY, 32'hAAAA_0000);
		send_call(MODE_SEND, 4'd2, 5'd1, 32'h5555_FFFF);
		send_call(MODE_SEND, 4'd4, 5'd5, 32'h0);
		send_call(MODE_SEND, 4'd6, 5'd5, 32'hFFFF_FFFF);
		send_call(MODE_SEND, 4'd4, 5'd7, 32'h9);
		send_call(MODE_RECV, 4'd5, 5'd6, 32'h1234_5678);
		send_call(MODE_RECV, 4'd5, PEER_ANY, 32'h8765_4321);
		send_call(MODE_SEND, 4'd5, 5'd4, 32'h7);
		send_call(MODE_SEND, 4'd4, 5'd5, 32'h8);
	endtask

	task automatic test_deadlock();
		send_call(MODE_SEND, 4'd8, 5'd9, 32'h10);
		send_call(MODE_SEND, 4'd9, 5'd10, 32'h11);
		send_call(MODE_SEND, 4'd10, 5'd8, 32'h12);
		send_call(MODE_RECV, 4'd11, 5'd12, 32'h13);
		send_call(MODE_SEND, 4'd12, 5'd11, 32'h14);
	endtask

	task automatic test_interrupts();
		send_call(MODE_INT, 4'd13, 5'd31, 32'h0);
		send_call(MODE_RECV, 4'd13, PEER_INT, 32'h20);
		send_call(MODE_RECV, 4'd14, PEER_INT, 32'h21);
		send_call(MODE_SEND, 4'd15, 5'd14, 32'h22);
		send_call(MODE_INT, 4'd14, 5'd0, 32'h23);
		send_call(MODE_RECV, 4'd14, PEER_ANY, 32'h24);
	endtask

	task automatic test_random(int count, bit with_hold);
		logic [1:0] mode;
		logic [4:0] peer;
		int r;
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 20)
				hold_active <= 1'b1;
			r = $urandom_range(0, 99);
			if (r < 45)
				mode = MODE_SEND;
			else if (r < 85)
				mode = MODE_RECV;
			else if (r < 95)
				mode = MODE_INT;
			else
				mode = MODE_BAD;
			r = $urandom_range(0, 99);
			if (r < 75)
				peer = 5'($urandom_range(0, 15));
			else if (r < 88)
				peer = PEER_ANY;
			else if (r < 95)
				peer = PEER_INT;
			else
				peer = 5'($urandom_range(18, 31));
			send_call(mode, 4'($urandom_range(0, 15)), peer, $urandom());
		end
	endtask

	initial begin
		int wait_cycles;
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rejects();
		test_rendezvous();
		test_deadlock();
		test_interrupts();
		test_random(450, 1);
		test_random(475, 0);
		req.valid <= 1'b0;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (60) @(posedge clk);
		if (expected_results.size() != 0)
			mismatches++;
		$display("%0d calls, %0d results: delivered %0d, blocked %0d, deadlock %0d,",
			items_sent, results_seen, status_count[0], status_count[1], status_count[2]);
		$display("interrupt written %0d, pending %0d, rejected %0d",
			status_count[3], status_count[4], status_count[5]);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
